@@ hw/rtl/lmd_pkg.sv @@
// ----------------------------------------------------------------------------
// lmd_pkg
// Shared types, codes and helpers of the label mask dilation block.
// ----------------------------------------------------------------------------
package lmd_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int LABEL_W    = 8;
    localparam int CLASS_W    = 2;

    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;
    typedef logic [LABEL_W-1:0]    t_label;
    typedef logic [CLASS_W-1:0]    t_class;

    localparam t_cfg_idx CFG_TARGET_LABEL = 2'd0;
    localparam t_cfg_idx CFG_FRAME_WIDTH  = 2'd1;
    localparam t_cfg_idx CFG_FRAME_HEIGHT = 2'd2;

    localparam t_class CLASS_NONE   = 2'd0;
    localparam t_class CLASS_TARGET = 2'd1;
    localparam t_class CLASS_OTHER  = 2'd2;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam t_label    RST_TARGET_LABEL = 8'd0;
    localparam t_cfg_data RST_FRAME_WIDTH  = 12'd1920;
    localparam t_cfg_data RST_FRAME_HEIGHT = 12'd1080;

    function automatic int unsigned clamp_size(t_cfg_data v, int unsigned max_size);
        int unsigned r;
        if (v == '0) begin
            r = 1;
        end else if (32'(v) > max_size) begin
            r = max_size;
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

    function automatic t_class classify(logic op, t_label label, t_label target);
        t_class c;
        if (op != OP_PIXEL) begin
            c = CLASS_NONE;
        end else if (label == target) begin
            c = CLASS_TARGET;
        end else if (label != '0) begin
            c = CLASS_OTHER;
        end else begin
            c = CLASS_NONE;
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/lmd_if.sv @@
// ----------------------------------------------------------------------------
// lmd_if
// Valid/ready channels of the label mask dilation block.
// ----------------------------------------------------------------------------
interface lmd_cfg_if;
    logic                 valid;
    logic                 ready;
    lmd_pkg::t_cfg_idx    index;
    lmd_pkg::t_cfg_data   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface lmd_pix_if;
    logic                 valid;
    logic                 ready;
    logic                 op;
    lmd_pkg::t_label      label;

    modport source (output valid, op, label, input ready);
    modport sink   (input valid, op, label, output ready);
endinterface

interface lmd_mask_if;
    logic                 valid;
    logic                 ready;
    lmd_pkg::t_class      mask_class;
    logic                 row_end;
    logic                 frame_end;

    modport source (output valid, mask_class, row_end, frame_end, input ready);
    modport sink   (input valid, mask_class, row_end, frame_end, output ready);
endinterface

@@ hw/rtl/label_mask_dilation_top.sv @@
// ----------------------------------------------------------------------------
// label_mask_dilation_top
// 3x3 dilation of a target/other class mask over a raster label stream.
// ----------------------------------------------------------------------------
// Usage:
//   i_cfg  : register writes (0 target label, 1 frame width, 2 frame height),
//            always ready; write only while no transaction is in flight.
//   i_pix  : one transaction per source pixel in raster order; op = drain
//            feeds a background pixel to flush the frame tail.
//   o_mask : one transaction per output pixel with its class and row/frame
//            end flags. Pixel k of a frame leaves with input transaction
//            k + width + 1, so width + 1 drains follow the last pixel.
// Throughput: one input transaction per cycle, set by the single read and
//   single write port of the line memory, one access each per pixel, while
//   o_mask does not stall. The input transaction that completes a result
//   passes the memory stage into the output register and can be taken there.
// Reset: counters, window and registers return to their defaults; the line
//   memory is not cleared, since entries that were never written fall on
//   window positions outside the frame.
// Stall: when o_mask is not ready the full output register holds, an emitting
//   pixel stays in the memory stage and i_pix.ready drops in that same cycle.
// ----------------------------------------------------------------------------
module label_mask_dilation_top #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lmd_cfg_if.sink     i_cfg,
    lmd_pix_if.sink     i_pix,
    lmd_mask_if.source  o_mask
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int SW = $clog2(MAX_WIDTH + 2);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int LW = 2 * lmd_pkg::CLASS_W;

    typedef struct packed {
        lmd_pkg::t_class fresh;
        logic [CW-1:0]   addr;
        logic            emit;
        logic            row_end;
        logic            frame_end;
        logic            row_top;
        logic            row_bot;
        logic            col_l;
        logic            col_r;
    } t_s1;

    lmd_pkg::t_label r_target;
    logic [WW-1:0]   r_w;
    logic [HW-1:0]   r_h;

    logic [CW-1:0]   r_ic, n_ic;
    logic [CW-1:0]   r_oc, n_oc;
    logic [RW-1:0]   r_or, n_or;
    logic [SW-1:0]   r_seen, n_seen;

    logic            r_s1_valid;
    t_s1             r_s1, n_s1;
    logic            r_fwd;
    logic [LW-1:0]   r_fwd_data;

    lmd_pkg::t_class r_win_c1 [3];
    lmd_pkg::t_class r_win_c2 [3];

    logic            r_out_valid;
    lmd_pkg::t_class r_out_class;
    logic            r_out_row_end;
    logic            r_out_frame_end;

    logic            pix_accept;
    logic            s1_fire;
    logic            out_free;
    logic [WW:0]     w_ext;
    logic [WW:0]     ic_inc;
    logic [WW:0]     oc_inc;
    logic [HW:0]     h_ext;
    logic [HW:0]     or_inc;
    logic            emit;
    logic            row_end;
    logic            last_row;
    logic            frame_end;

    logic [LW-1:0]   ram_rdata;
    logic [LW-1:0]   line_rd;
    logic [LW-1:0]   ram_wdata;
    lmd_pkg::t_class line_top;
    lmd_pkg::t_class line_mid;
    lmd_pkg::t_class result;

    // ------------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= lmd_pkg::RST_TARGET_LABEL;
            r_w      <= WW'(lmd_pkg::clamp_size(lmd_pkg::RST_FRAME_WIDTH, MAX_WIDTH));
            r_h      <= HW'(lmd_pkg::clamp_size(lmd_pkg::RST_FRAME_HEIGHT, MAX_HEIGHT));
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                lmd_pkg::CFG_TARGET_LABEL: begin
                    r_target <= i_cfg.data[lmd_pkg::LABEL_W-1:0];
                end
                lmd_pkg::CFG_FRAME_WIDTH: begin
                    r_w <= WW'(lmd_pkg::clamp_size(i_cfg.data, MAX_WIDTH));
                end
                lmd_pkg::CFG_FRAME_HEIGHT: begin
                    r_h <= HW'(lmd_pkg::clamp_size(i_cfg.data, MAX_HEIGHT));
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Position counters at input acceptance
    // ------------------------------------------------------------------------
    assign out_free   = !r_out_valid || o_mask.ready;
    assign s1_fire    = r_s1_valid && (!r_s1.emit || out_free);
    assign i_pix.ready = !r_s1_valid || s1_fire;
    assign pix_accept = i_pix.valid && i_pix.ready;

    assign w_ext     = (WW+1)'(r_w);
    assign h_ext     = (HW+1)'(r_h);
    assign ic_inc    = (WW+1)'(r_ic) + (WW+1)'(1);
    assign oc_inc    = (WW+1)'(r_oc) + (WW+1)'(1);
    assign or_inc    = (HW+1)'(r_or) + (HW+1)'(1);
    assign emit      = (WW+1)'(r_seen) >= w_ext + (WW+1)'(1);
    assign row_end   = oc_inc >= w_ext;
    assign last_row  = or_inc >= h_ext;
    assign frame_end = row_end && last_row;

    always_comb begin
        n_ic   = (ic_inc >= w_ext) ? '0 : CW'(ic_inc);
        n_oc   = r_oc;
        n_or   = r_or;
        n_seen = r_seen;
        if (!emit) begin
            n_seen = r_seen + SW'(1);
        end else if (frame_end) begin
            n_ic   = '0;
            n_oc   = '0;
            n_or   = '0;
            n_seen = '0;
        end else if (row_end) begin
            n_oc = '0;
            n_or = RW'(or_inc);
        end else begin
            n_oc = CW'(oc_inc);
        end

        n_s1.fresh     = lmd_pkg::classify(i_pix.op, i_pix.label, r_target);
        n_s1.addr      = r_ic;
        n_s1.emit      = emit;
        n_s1.row_end   = row_end;
        n_s1.frame_end = frame_end;
        n_s1.row_top   = r_or != '0;
        n_s1.row_bot   = !last_row;
        n_s1.col_l     = r_oc != '0;
        n_s1.col_r     = !row_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ic       <= '0;
            r_oc       <= '0;
            r_or       <= '0;
            r_seen     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (pix_accept) begin
                r_ic   <= n_ic;
                r_oc   <= n_oc;
                r_or   <= n_or;
                r_seen <= n_seen;
            end
            if (pix_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_accept) begin
            r_s1       <= n_s1;
            r_fwd      <= s1_fire && (r_s1.addr == r_ic);
            r_fwd_data <= ram_wdata;
        end
    end

    // ------------------------------------------------------------------------
    // Line memory: {upper row class, middle row class} per column
    // ------------------------------------------------------------------------
    assign line_rd   = r_fwd ? r_fwd_data : ram_rdata;
    assign line_top  = line_rd[LW-1 -: lmd_pkg::CLASS_W];
    assign line_mid  = line_rd[lmd_pkg::CLASS_W-1:0];
    assign ram_wdata = {line_mid, r_s1.fresh};

    lmd_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1.addr),
        .i_wdata (ram_wdata),
        .i_re    (pix_accept),
        .i_raddr (r_ic),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------------
    // Window and neighbourhood pick
    // ------------------------------------------------------------------------
    always_comb begin
        lmd_pkg::t_class win  [3][3];
        lmd_pkg::t_class pick [3];
        win[0][2] = line_top;
        win[1][2] = line_mid;
        win[2][2] = r_s1.fresh;
        for (int r = 0; r < 3; r++) begin
            win[r][0] = r_win_c1[r];
            win[r][1] = r_win_c2[r];
            if (r_s1.col_r && win[r][2] != lmd_pkg::CLASS_NONE) begin
                pick[r] = win[r][2];
            end else if (win[r][1] != lmd_pkg::CLASS_NONE) begin
                pick[r] = win[r][1];
            end else if (r_s1.col_l) begin
                pick[r] = win[r][0];
            end else begin
                pick[r] = lmd_pkg::CLASS_NONE;
            end
        end
        if (r_s1.row_bot && pick[2] != lmd_pkg::CLASS_NONE) begin
            result = pick[2];
        end else if (pick[1] != lmd_pkg::CLASS_NONE) begin
            result = pick[1];
        end else if (r_s1.row_top) begin
            result = pick[0];
        end else begin
            result = lmd_pkg::CLASS_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                r_win_c1[r] <= lmd_pkg::CLASS_NONE;
                r_win_c2[r] <= lmd_pkg::CLASS_NONE;
            end
        end else if (s1_fire) begin
            for (int r = 0; r < 3; r++) begin
                r_win_c1[r] <= r_win_c2[r];
            end
            r_win_c2[0] <= line_top;
            r_win_c2[1] <= line_mid;
            r_win_c2[2] <= r_s1.fresh;
        end
    end

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_mask.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1.emit) begin
            r_out_class     <= result;
            r_out_row_end   <= r_s1.row_end;
            r_out_frame_end <= r_s1.frame_end;
        end
    end

    assign o_mask.valid      = r_out_valid;
    assign o_mask.mask_class = r_out_class;
    assign o_mask.row_end    = r_out_row_end;
    assign o_mask.frame_end  = r_out_frame_end;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_class_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_class == lmd_pkg::CLASS_NONE ||
                         r_out_class == lmd_pkg::CLASS_TARGET ||
                         r_out_class == lmd_pkg::CLASS_OTHER))
        else $error("illegal mask class in output register");

    a_frame_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_frame_end) |-> r_out_row_end)
        else $error("frame end without row end");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_mask.ready) |-> !(s1_fire && r_s1.emit))
        else $error("pending output overwritten");

    a_rdata_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_fire) |=> $stable(ram_rdata))
        else $error("line read data lost while stalled");

    a_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pix_accept && s1_fire && r_s1.addr == r_ic) |=> r_fwd)
        else $error("missing forward on same-column access");

endmodule

@@ hw/rtl/lmd_ram.sv @@
// ----------------------------------------------------------------------------
// lmd_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lmd_ram #(
    parameter  int WIDTH = 4,
    parameter  int DEPTH = 2048,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
